// File: src/thumb16_instruction_decoder_top_macros.svh
// Assertion macros used by the decoder top
`ifndef THUMB16_INSTRUCTION_DECODER_TOP_MACROS_SVH
`define THUMB16_INSTRUCTION_DECODER_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define T16_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define T16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/t16dec_pkg.sv
// ---------------------------------------------------------------------------
// t16dec_pkg
// Types and mnemonic codes shared by the Thumb decoder modules.
// ---------------------------------------------------------------------------
package t16dec_pkg;

  localparam logic [6:0] M_UNDEF     = 7'd0;
  localparam logic [6:0] M_LSL_I     = 7'd1;
  localparam logic [6:0] M_LSR_I     = 7'd2;
  localparam logic [6:0] M_ASR_I     = 7'd3;
  localparam logic [6:0] M_ADD_R3    = 7'd4;
  localparam logic [6:0] M_SUB_R3    = 7'd5;
  localparam logic [6:0] M_ADD_I3    = 7'd6;
  localparam logic [6:0] M_SUB_I3    = 7'd7;
  localparam logic [6:0] M_MOV_I8    = 7'd8;
  localparam logic [6:0] M_CMP_I8    = 7'd9;
  localparam logic [6:0] M_ADD_I8    = 7'd10;
  localparam logic [6:0] M_SUB_I8    = 7'd11;
  localparam logic [6:0] M_DP_BASE   = 7'd12;
  localparam logic [6:0] M_ADD_HI    = 7'd28;
  localparam logic [6:0] M_CMP_HI    = 7'd29;
  localparam logic [6:0] M_MOV_HI    = 7'd30;
  localparam logic [6:0] M_CPY       = 7'd31;
  localparam logic [6:0] M_BX        = 7'd32;
  localparam logic [6:0] M_BLX_R     = 7'd33;
  localparam logic [6:0] M_LDR_PC    = 7'd34;
  localparam logic [6:0] M_RO_BASE   = 7'd35;
  localparam logic [6:0] M_STR_I     = 7'd43;
  localparam logic [6:0] M_LDR_I     = 7'd44;
  localparam logic [6:0] M_STRB_I    = 7'd45;
  localparam logic [6:0] M_LDRB_I    = 7'd46;
  localparam logic [6:0] M_STRH_I    = 7'd47;
  localparam logic [6:0] M_LDRH_I    = 7'd48;
  localparam logic [6:0] M_STR_SP    = 7'd49;
  localparam logic [6:0] M_LDR_SP    = 7'd50;
  localparam logic [6:0] M_ADR_PC    = 7'd51;
  localparam logic [6:0] M_ADD_SPREL = 7'd52;
  localparam logic [6:0] M_ADD_SP    = 7'd53;
  localparam logic [6:0] M_SUB_SP    = 7'd54;
  localparam logic [6:0] M_EXT_BASE  = 7'd55;
  localparam logic [6:0] M_REV       = 7'd59;
  localparam logic [6:0] M_REV16     = 7'd60;
  localparam logic [6:0] M_REVSH     = 7'd61;
  localparam logic [6:0] M_PUSH      = 7'd62;
  localparam logic [6:0] M_POP       = 7'd63;
  localparam logic [6:0] M_SETEND    = 7'd64;
  localparam logic [6:0] M_CPSIE     = 7'd65;
  localparam logic [6:0] M_CPSID     = 7'd66;
  localparam logic [6:0] M_BKPT      = 7'd67;
  localparam logic [6:0] M_STMIA     = 7'd68;
  localparam logic [6:0] M_LDMIA     = 7'd69;
  localparam logic [6:0] M_BCOND     = 7'd70;
  localparam logic [6:0] M_SWI       = 7'd71;
  localparam logic [6:0] M_B         = 7'd72;
  localparam logic [6:0] M_BLX_SUF   = 7'd73;
  localparam logic [6:0] M_BL_PRE    = 7'd74;
  localparam logic [6:0] M_BL_SUF    = 7'd75;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;
  localparam logic [3:0] COND_NONE = 4'd14;
  localparam logic [3:0] COND_SWI  = 4'd15;

  // packed MSB-first: mnemonic, declared last, is the lowest field
  typedef struct packed {
    logic              invalid;
    logic [2:0]        mode_flags;
    logic [8:0]        register_list;
    logic [3:0]        condition;
    logic signed [23:0] branch_offset;
    logic [9:0]        immediate;
    logic [3:0]        second_src_reg;
    logic [3:0]        first_src_reg;
    logic [3:0]        dest_reg;
    logic [6:0]        mnemonic;
  } dec_result_t;

  typedef struct packed {
    logic        pending;
    logic [10:0] value;
  } prefix_state_t;

endpackage

// File: src/t16dec_logic.sv
// ---------------------------------------------------------------------------
// t16dec_logic
// Combinational decode of one halfword against the held BL/BLX prefix.
// ---------------------------------------------------------------------------
module t16dec_logic (
  input  logic [15:0]                 instruction,
  input  t16dec_pkg::prefix_state_t   prefix,
  output t16dec_pkg::dec_result_t     result,
  output t16dec_pkg::prefix_state_t   prefix_next
);
  import t16dec_pkg::*;

  logic [2:0]  rd, rs, rb, r8;
  logic [4:0]  i5;
  logic [7:0]  i8;
  logic [10:0] i11;
  logic        b11;
  logic [3:0]  hd, hm, cond;
  logic        undef, keep, was;
  logic [23:0] off;
  logic [23:0] sum_off;
  dec_result_t r;

  assign rd  = instruction[2:0];
  assign rs  = instruction[5:3];
  assign rb  = instruction[8:6];
  assign r8  = instruction[10:8];
  assign i5  = instruction[10:6];
  assign i8  = instruction[7:0];
  assign i11 = instruction[10:0];
  assign b11 = instruction[11];
  assign hd  = {instruction[7], rd};
  assign hm  = instruction[6:3];
  assign cond = instruction[11:8];

  // prefix<<12 sign-extended, plus 4 and suffix*2
  assign sum_off = {prefix.value[10], prefix.value, 12'd0}
                 + {12'd0, i11, 1'b0} + 24'd4;

  always_comb begin
    r     = '0;
    undef = 1'b0;
    keep  = 1'b0;
    was   = prefix.pending;
    off   = '0;
    unique case (instruction[15:12])
      4'd0: begin
        r.mnemonic = b11 ? M_LSR_I : M_LSL_I;
        r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
        r.immediate = (b11 && i5 == 5'd0) ? 10'd32 : {5'd0, i5};
      end
      4'd1: begin
        r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
        if (!b11) begin
          r.mnemonic = M_ASR_I;
          r.immediate = (i5 == 5'd0) ? 10'd32 : {5'd0, i5};
        end else if (!instruction[10]) begin
          r.mnemonic = instruction[9] ? M_SUB_R3 : M_ADD_R3;
          r.second_src_reg = {1'b0, rb};
        end else begin
          r.mnemonic = instruction[9] ? M_SUB_I3 : M_ADD_I3;
          r.immediate = {7'd0, rb};
        end
      end
      4'd2: begin
        r.mnemonic = b11 ? M_CMP_I8 : M_MOV_I8;
        r.dest_reg = {1'b0, r8}; r.immediate = {2'd0, i8};
      end
      4'd3: begin
        r.mnemonic = b11 ? M_SUB_I8 : M_ADD_I8;
        r.dest_reg = {1'b0, r8}; r.first_src_reg = {1'b0, r8};
        r.immediate = {2'd0, i8};
      end
      4'd4: begin
        if (b11) begin
          r.mnemonic = M_LDR_PC; r.dest_reg = {1'b0, r8};
          r.first_src_reg = REG_PC; r.immediate = {i8, 2'b00};
        end else if (!instruction[10]) begin
          r.mnemonic = M_DP_BASE + {3'd0, instruction[9:6]};
          r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
        end else if (instruction[9:8] == 2'd3) begin
          r.mnemonic = instruction[7] ? M_BLX_R : M_BX;
          r.second_src_reg = hm;
        end else begin
          r.dest_reg = hd; r.first_src_reg = hm;
          case (instruction[9:8])
            2'd0:    r.mnemonic = M_ADD_HI;
            2'd1:    r.mnemonic = M_CMP_HI;
            default: r.mnemonic = (!hd[3] && !hm[3]) ? M_CPY : M_MOV_HI;
          endcase
        end
      end
      4'd5: begin
        r.mnemonic = M_RO_BASE + {4'd0, instruction[11:9]};
        r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
        r.second_src_reg = {1'b0, rb};
      end
      4'd6: begin
        r.mnemonic = b11 ? M_LDR_I : M_STR_I;
        r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
        r.immediate = {3'd0, i5, 2'b00};
      end
      4'd7: begin
        r.mnemonic = b11 ? M_LDRB_I : M_STRB_I;
        r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
        r.immediate = {5'd0, i5};
      end
      4'd8: begin
        r.mnemonic = b11 ? M_LDRH_I : M_STRH_I;
        r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
        r.immediate = {4'd0, i5, 1'b0};
      end
      4'd9: begin
        r.mnemonic = b11 ? M_LDR_SP : M_STR_SP;
        r.dest_reg = {1'b0, r8}; r.first_src_reg = REG_SP;
        r.immediate = {i8, 2'b00};
      end
      4'd10: begin
        r.mnemonic = b11 ? M_ADD_SPREL : M_ADR_PC;
        r.dest_reg = {1'b0, r8}; r.first_src_reg = b11 ? REG_SP : REG_PC;
        r.immediate = {i8, 2'b00};
      end
      4'd11: begin
        case (instruction[11:8])
          4'd0: begin
            r.mnemonic = instruction[7] ? M_SUB_SP : M_ADD_SP;
            r.dest_reg = REG_SP; r.first_src_reg = REG_SP;
            r.immediate = {1'b0, instruction[6:0], 2'b00};
          end
          4'd2: begin
            r.mnemonic = M_EXT_BASE + {5'd0, instruction[7:6]};
            r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
          end
          4'd4, 4'd5: begin
            r.mnemonic = M_PUSH; r.first_src_reg = REG_SP;
            r.register_list = instruction[8:0];
          end
          4'd12, 4'd13: begin
            r.mnemonic = M_POP; r.first_src_reg = REG_SP;
            r.register_list = instruction[8:0];
          end
          4'd6: begin
            if (!instruction[5]) begin
              r.mnemonic = M_SETEND; r.mode_flags = {2'd0, instruction[3]};
            end else begin
              r.mnemonic = instruction[4] ? M_CPSID : M_CPSIE;
              r.mode_flags = instruction[2:0];
            end
          end
          4'd10: begin
            r.dest_reg = {1'b0, rd}; r.first_src_reg = {1'b0, rs};
            case (instruction[7:6])
              2'd0:    r.mnemonic = M_REV;
              2'd1:    r.mnemonic = M_REV16;
              2'd3:    r.mnemonic = M_REVSH;
              default: undef = 1'b1;
            endcase
          end
          4'd14: begin
            r.mnemonic = M_BKPT; r.immediate = {2'd0, i8};
          end
          default: undef = 1'b1;
        endcase
      end
      4'd12: begin
        r.mnemonic = b11 ? M_LDMIA : M_STMIA;
        r.first_src_reg = {1'b0, r8}; r.register_list = {1'b0, i8};
      end
      4'd13: begin
        if (cond == COND_NONE) begin
          undef = 1'b1;
        end else if (cond == COND_SWI) begin
          r.mnemonic = M_SWI; r.immediate = {2'd0, i8};
        end else begin
          r.mnemonic = M_BCOND; r.condition = cond;
          off = {{15{i8[7]}}, i8, 1'b0} + 24'd4;
        end
      end
      default: begin
        if (instruction[15:12] == 4'd14 && !b11) begin
          r.mnemonic = M_B;
          off = {{12{i11[10]}}, i11, 1'b0} + 24'd4;
        end else if (instruction[15:12] == 4'd15 && !b11) begin
          r.mnemonic = M_BL_PRE;
          off = {i11[10], i11, 12'd0};
          keep = 1'b1;
        end else begin
          r.mnemonic = instruction[12] ? M_BL_SUF : M_BLX_SUF;
          if (was) begin
            off = instruction[12] ? sum_off : {sum_off[23:2], 2'b00};
            was = 1'b0;
          end else begin
            r.invalid = 1'b1;
          end
        end
      end
    endcase
    r.branch_offset = off;
    if (was) r.invalid = 1'b1;
    if (undef) begin
      r = '0;
      r.invalid = 1'b1;
    end
    result = r;
    prefix_next.pending = keep;
    prefix_next.value   = keep ? i11 : prefix.value;
  end

endmodule

// File: src/thumb16_instruction_decoder_top.sv
// ---------------------------------------------------------------------------
// thumb16_instruction_decoder_top
// Thumb 16-bit decoder with BL/BLX prefix joining, one halfword per cycle unless the output stalls.
// ---------------------------------------------------------------------------
// One request in, one decoded result out. A halfword is
// taken every cycle while the output register is empty or being drained; the
// decode is a single combinational pass into the result register. A BL/BLX
// prefix is held until the next halfword arrives and is joined to its suffix.
module thumb16_instruction_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // instruction[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // mnemonic[6:0] dest_reg[10:7] first_src_reg[14:11] second_src_reg[18:15]
  // immediate[28:19] branch_offset[52:29] condition[56:53]
  // register_list[65:57] mode_flags[68:66] invalid[69], zero to [71]
  output logic [71:0] m_tdata
);
  import t16dec_pkg::*;
  `include "thumb16_instruction_decoder_top_macros.svh"

  prefix_state_t prefix, prefix_next;
  dec_result_t   result_next, result;
  logic          take;

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  t16dec_logic u_logic (
    .instruction (s_tdata),
    .prefix      (prefix),
    .result      (result_next),
    .prefix_next (prefix_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) prefix <= prefix_next;
      if (take) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) result <= result_next;
  end

  assign m_tdata = {2'b00, result};

  `T16_ASSERT_NEXT(a_prefix_held, take && s_tdata[15:11] == 5'b11110,
    prefix.pending, "prefix not held")
  `T16_ASSERT_NEXT(a_prefix_drop, take && s_tdata[15:11] != 5'b11110,
    !prefix.pending, "prefix not dropped")
  `T16_ASSERT_IMP(a_undef_clean, m_tvalid && result.mnemonic == M_UNDEF,
    result.invalid && result.branch_offset == '0, "undef result not cleared")
  `T16_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "result lost while stalled")

endmodule

// File: verif/thumb16_instruction_decoder_checker.sv
// ---------------------------------------------------------------------------
// thumb16_instruction_decoder_checker
// Watches both streams, decodes each accepted halfword and compares results.
// ---------------------------------------------------------------------------
module thumb16_instruction_decoder_checker
  import t16dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          decoded_count
);
  timeunit 1ns;
  timeprecision 1ps;

  dec_result_t   decoded_q[$];
  prefix_state_t bl_prefix;

  function automatic logic [23:0] sext8x2(logic [7:0] v);
    return {{15{v[7]}}, v, 1'b0};
  endfunction

  function automatic dec_result_t decode_halfword(logic [15:0] x, ref prefix_state_t pfx);
    dec_result_t r;
    logic undef, keep, was, b11;
    logic [3:0] hd, hm, lo, mid, hi3;
    logic [23:0] off;
    r = '0;
    undef = 0;
    keep = 0;
    was = pfx.pending;
    b11 = x[11];
    hd = {x[7], x[2:0]};
    hm = x[6:3];
    lo = {1'b0, x[2:0]};
    mid = {1'b0, x[5:3]};
    hi3 = {1'b0, x[10:8]};
    off = '0;
    case (x[15:12])
      4'd0: begin
        r.mnemonic = b11 ? M_LSR_I : M_LSL_I;
        r.dest_reg = lo; r.first_src_reg = mid; r.immediate = {5'd0, x[10:6]};
        if (b11 && x[10:6] == 5'd0) r.immediate = 10'd32;
      end
      4'd1: begin
        r.dest_reg = lo; r.first_src_reg = mid;
        if (!b11) begin
          r.mnemonic = M_ASR_I;
          r.immediate = (x[10:6] == 5'd0) ? 10'd32 : {5'd0, x[10:6]};
        end else if (!x[10]) begin
          r.mnemonic = x[9] ? M_SUB_R3 : M_ADD_R3; r.second_src_reg = {1'b0, x[8:6]};
        end else begin
          r.mnemonic = x[9] ? M_SUB_I3 : M_ADD_I3; r.immediate = {7'd0, x[8:6]};
        end
      end
      4'd2: begin
        r.mnemonic = b11 ? M_CMP_I8 : M_MOV_I8; r.dest_reg = hi3;
        r.immediate = {2'd0, x[7:0]};
      end
      4'd3: begin
        r.mnemonic = b11 ? M_SUB_I8 : M_ADD_I8; r.dest_reg = hi3;
        r.first_src_reg = hi3; r.immediate = {2'd0, x[7:0]};
      end
      4'd4: begin
        if (b11) begin
          r.mnemonic = M_LDR_PC; r.dest_reg = hi3; r.first_src_reg = REG_PC;
          r.immediate = {x[7:0], 2'b00};
        end else if (!x[10]) begin
          r.mnemonic = M_DP_BASE + {3'd0, x[9:6]}; r.dest_reg = lo; r.first_src_reg = mid;
        end else if (x[9:8] == 2'd3) begin
          r.mnemonic = x[7] ? M_BLX_R : M_BX; r.second_src_reg = hm;
        end else begin
          r.dest_reg = hd; r.first_src_reg = hm;
          case (x[9:8])
            2'd0: r.mnemonic = M_ADD_HI;
            2'd1: r.mnemonic = M_CMP_HI;
            default: r.mnemonic = (!hd[3] && !hm[3]) ? M_CPY : M_MOV_HI;
          endcase
        end
      end
      4'd5: begin
        r.mnemonic = M_RO_BASE + {4'd0, x[11:9]}; r.dest_reg = lo;
        r.first_src_reg = mid; r.second_src_reg = {1'b0, x[8:6]};
      end
      4'd6, 4'd7, 4'd8: begin
        r.dest_reg = lo; r.first_src_reg = mid;
        if (x[15:12] == 4'd6) begin
          r.mnemonic = b11 ? M_LDR_I : M_STR_I; r.immediate = {3'd0, x[10:6], 2'b00};
        end else if (x[15:12] == 4'd7) begin
          r.mnemonic = b11 ? M_LDRB_I : M_STRB_I; r.immediate = {5'd0, x[10:6]};
        end else begin
          r.mnemonic = b11 ? M_LDRH_I : M_STRH_I; r.immediate = {4'd0, x[10:6], 1'b0};
        end
      end
      4'd9: begin
        r.mnemonic = b11 ? M_LDR_SP : M_STR_SP; r.dest_reg = hi3;
        r.first_src_reg = REG_SP; r.immediate = {x[7:0], 2'b00};
      end
      4'd10: begin
        r.mnemonic = b11 ? M_ADD_SPREL : M_ADR_PC; r.dest_reg = hi3;
        r.first_src_reg = b11 ? REG_SP : REG_PC; r.immediate = {x[7:0], 2'b00};
      end
      4'd11: begin
        case (x[11:8])
          4'd0: begin
            r.mnemonic = x[7] ? M_SUB_SP : M_ADD_SP; r.dest_reg = REG_SP;
            r.first_src_reg = REG_SP; r.immediate = {1'b0, x[6:0], 2'b00};
          end
          4'd2: begin
            r.mnemonic = M_EXT_BASE + {5'd0, x[7:6]}; r.dest_reg = lo; r.first_src_reg = mid;
          end
          4'd4, 4'd5, 4'd12, 4'd13: begin
            r.mnemonic = x[11] ? M_POP : M_PUSH; r.first_src_reg = REG_SP;
            r.register_list = x[8:0];
          end
          4'd6: begin
            if (!x[5]) begin
              r.mnemonic = M_SETEND; r.mode_flags = {2'd0, x[3]};
            end else begin
              r.mnemonic = x[4] ? M_CPSID : M_CPSIE; r.mode_flags = x[2:0];
            end
          end
          4'd10: begin
            if (x[7:6] == 2'd2) undef = 1;
            else begin
              r.mnemonic = (x[7:6] == 2'd0) ? M_REV : (x[7:6] == 2'd1) ? M_REV16 : M_REVSH;
              r.dest_reg = lo; r.first_src_reg = mid;
            end
          end
          4'd14: begin
            r.mnemonic = M_BKPT; r.immediate = {2'd0, x[7:0]};
          end
          default: undef = 1;
        endcase
      end
      4'd12: begin
        r.mnemonic = b11 ? M_LDMIA : M_STMIA; r.first_src_reg = hi3;
        r.register_list = {1'b0, x[7:0]};
      end
      4'd13: begin
        if (x[11:8] == COND_NONE) undef = 1;
        else if (x[11:8] == COND_SWI) begin
          r.mnemonic = M_SWI; r.immediate = {2'd0, x[7:0]};
        end else begin
          r.mnemonic = M_BCOND; r.condition = x[11:8]; off = 24'd4 + sext8x2(x[7:0]);
        end
      end
      default: begin
        if (x[15:12] == 4'd14 && !b11) begin
          r.mnemonic = M_B; off = 24'd4 + {{12{x[10]}}, x[10:0], 1'b0};
        end else if (x[15:12] == 4'd15 && !b11) begin
          r.mnemonic = M_BL_PRE; off = {{2{x[10]}}, x[10:0], 11'd0} << 1;
          keep = 1;
        end else begin
          r.mnemonic = (x[15:12] == 4'd14) ? M_BLX_SUF : M_BL_SUF;
          if (was) begin
            off = 24'd4 + {pfx.value[10], pfx.value, 12'd0} + {12'd0, x[10:0], 1'b0};
            if (r.mnemonic == M_BLX_SUF) off[1:0] = 2'b00;
            was = 0;
          end else r.invalid = 1;
        end
      end
    endcase
    r.branch_offset = off;
    if (was) r.invalid = 1;
    pfx.pending = keep;
    if (keep) pfx.value = x[10:0];
    if (undef) begin
      r = '0;
      r.invalid = 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dec_result_t got, want;
    if (rst) begin
      bl_prefix <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        prefix_state_t p;
        p = bl_prefix;
        decoded_q.push_back(decode_halfword(s_tdata, p));
        bl_prefix <= p;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[69:0];
        decoded_count++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unrequested result", 1, 0);
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata[71:70] != 2'b00) report_mismatch("pad bits", int'(m_tdata[71:70]), 0);
          if (got.mnemonic != want.mnemonic)
            report_mismatch("mnemonic", got.mnemonic, want.mnemonic);
          if (got.dest_reg != want.dest_reg) report_mismatch("dest_reg", got.dest_reg, want.dest_reg);
          if (got.first_src_reg != want.first_src_reg)
            report_mismatch("first_src_reg", got.first_src_reg, want.first_src_reg);
          if (got.second_src_reg != want.second_src_reg)
            report_mismatch("second_src_reg", got.second_src_reg, want.second_src_reg);
          if (got.immediate != want.immediate)
            report_mismatch("immediate", got.immediate, want.immediate);
          if (got.branch_offset != want.branch_offset)
            report_mismatch("branch_offset", got.branch_offset, want.branch_offset);
          if (got.condition != want.condition)
            report_mismatch("condition", got.condition, want.condition);
          if (got.register_list != want.register_list)
            report_mismatch("register_list", got.register_list, want.register_list);
          if (got.mode_flags != want.mode_flags)
            report_mismatch("mode_flags", got.mode_flags, want.mode_flags);
          if (got.invalid != want.invalid) report_mismatch("invalid", got.invalid, want.invalid);
        end
      end
    end
    pending_count <= decoded_q.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
    decoded_count = 0;
  end
endmodule

// File: verif/thumb16_instruction_decoder_top_tb.sv
// ---------------------------------------------------------------------------
// thumb16_instruction_decoder_top_tb
// Directed and random halfword streams, with BL/BLX pairs, into the decoder.
// ---------------------------------------------------------------------------
module thumb16_instruction_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [15:0] s_tdata;
  logic [71:0] m_tdata;
  int          fail_count, pending_count, decoded_count;
  int          idle_cycles;
  int          sent;

  thumb16_instruction_decoder_top dut (.*);

  thumb16_instruction_decoder_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern: stretches of random length, each ready or stalled at random
  initial begin
    int run;
    m_tready = 0;
    @(negedge clk);
    forever begin
      run = $urandom_range(1, 12);
      m_tready = ($urandom_range(0, 2) != 0);
      repeat (run) @(negedge clk);
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_count);
      $display("[thumb16_instruction_decoder_top] ERROR");
      $finish;
    end
  end

  task automatic send_halfword(logic [15:0] hw);
    s_tdata  <= hw;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [15:0] random_halfword();
    logic [15:0] h;
    h = 16'($urandom);
    return h;
  endfunction

  initial begin
    logic [15:0] directed[];
    int burst;
    directed = '{
      16'h0000, 16'hFFFF, 16'h0800, 16'h1000, 16'h07FF, 16'h1E3F, 16'h1A3F,
      16'h46C0, 16'h4600, 16'h4477, 16'h47F8, 16'h4780, 16'hBA80, 16'hBB00,
      16'hB6F7, 16'hB658, 16'hB5FF, 16'hBDFF, 16'hDE00, 16'hDF7F, 16'hD080,
      16'hF7FF, 16'hE800, 16'hF400, 16'hF800
    };
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    sent = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed[i]) send_halfword(directed[i]);
    pause_sender();

    while (sent < 1400) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            // well-formed BL or BLX pair with random offsets
            send_halfword({5'b11110, 11'($urandom)});
            send_halfword({$urandom_range(0, 1) ? 5'b11111 : 5'b11101, 11'($urandom)});
          end
          3: begin
            // prefix followed by a random halfword, which may or may not be a suffix
            send_halfword({5'b11110, 11'($urandom)});
            send_halfword(random_halfword());
          end
          default: send_halfword(random_halfword());
        endcase
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    s_tvalid <= 1'b0;

    while (pending_count != 0 || chk.decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d halfwords including BL/BLX pairs and broken prefix sequences;", sent);
    $display("%0d decoded results compared field by field", decoded_count);
    if (fail_count == 0) $display("[thumb16_instruction_decoder_top] OK");
    else $display("[thumb16_instruction_decoder_top] ERROR");
    $finish;
  end
endmodule
